/* rtl/mww_pkg.sv */
package mww_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] WIDTH_RESET  = 8'd80;
    localparam int         FIFO_DEPTH   = 4;
    localparam int         PTR_W        = $clog2(FIFO_DEPTH);
    localparam int         CNT_W        = $clog2(FIFO_DEPTH + 1);
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [15:0] line_start;
        logic [8:0]  line_length;
        logic        is_final;
        logic [15:0] lines_so_far;
        logic [8:0]  widest_so_far;
    } res_t;

    // first: one word to queue; second: a second word follows it
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    function automatic logic is_blank(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20) || (c == 8'h85) || (c == 8'hA0);
        return r;
    endfunction

endpackage

/* rtl/mww_core.sv */
module mww_core
    import mww_pkg::*;
#(
    parameter int MAX_WIDTH     = 255,
    parameter int POSITION_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       accept,
    input  logic [7:0] char_code,
    input  logic       is_last,
    input  logic       end_only,
    output push_t      push,
    output res_t       res0,
    output res_t       res1
);

    localparam int CW = $clog2(MAX_WIDTH + 2);
    localparam int PB = POSITION_BITS;
    localparam int WB = (CW > 8) ? CW : 8;

    logic [7:0]    wrap_width_reg;
    logic [PB-1:0] text_pos_reg, text_pos_next;
    logic [PB-1:0] start_reg, start_next;
    logic [CW-1:0] chars_reg, chars_next;
    logic [CW-1:0] space_reg, space_next;
    logic [15:0]   count_reg, count_next;
    logic [CW-1:0] widest_reg, widest_next;

    logic [WB-1:0] ww_ext;
    logic [CW-1:0] w;
    logic          w_zero;
    logic [PB-1:0] pos_inc;
    logic          nl;
    logic          blank;
    logic          ends;
    logic          r1_valid;
    logic [CW-1:0] r1_len;
    logic [PB-1:0] lstart;
    logic [CW-1:0] lchars;
    logic [CW-1:0] lspace;
    logic [15:0]   cnt1, cnt2;
    logic [CW-1:0] wid1, wid2;
    logic          r2_valid;
    res_t          r1, r2;

    assign ww_ext  = WB'(wrap_width_reg);
    assign w       = (ww_ext > WB'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(ww_ext);
    assign w_zero  = (w == '0);
    assign pos_inc = text_pos_reg + PB'(1);
    assign nl      = (char_code == NEWLINE_CODE);
    assign blank   = is_blank(char_code);

    always_comb
    begin
        lstart   = start_reg;
        lchars   = chars_reg;
        lspace   = space_reg;
        r1_valid = 1'b0;
        r1_len   = chars_reg;
        ends     = 1'b1;
        text_pos_next = text_pos_reg;
        if (!end_only)
        begin
            ends          = is_last;
            text_pos_next = pos_inc;
            if (w_zero)
            begin
                lstart = pos_inc;
                lchars = '0;
                lspace = '0;
            end
            else if (chars_reg < w)
            begin
                if (nl)
                begin
                    r1_valid = 1'b1;
                    lstart   = pos_inc;
                    lchars   = '0;
                    lspace   = '0;
                end
                else
                begin
                    if (blank && (chars_reg != '0))
                    begin
                        lspace = chars_reg;
                    end
                    lchars = chars_reg + CW'(1);
                end
            end
            else if (nl)
            begin
                r1_valid = 1'b1;
                lstart   = pos_inc;
                lchars   = '0;
                lspace   = '0;
            end
            else if (blank)
            begin
                r1_valid = 1'b1;
                r1_len   = chars_reg + CW'(1);
                lstart   = pos_inc;
                lchars   = '0;
                lspace   = '0;
            end
            else if ((space_reg != '0) && (space_reg < chars_reg))
            begin
                r1_valid = 1'b1;
                r1_len   = space_reg + CW'(1);
                lstart   = start_reg + PB'(space_reg) + PB'(1);
                lchars   = chars_reg - space_reg;
                lspace   = '0;
            end
            else
            begin
                r1_valid = 1'b1;
                lstart   = text_pos_reg;
                lchars   = CW'(1);
                lspace   = '0;
            end
        end
    end

    // running stats after the first and second line
    always_comb
    begin
        cnt1 = count_reg;
        wid1 = widest_reg;
        if (r1_valid)
        begin
            if (count_reg != COUNT_MAX)
            begin
                cnt1 = count_reg + 16'd1;
            end
            if (r1_len > widest_reg)
            begin
                wid1 = r1_len;
            end
        end
        r2_valid = ends && !w_zero;
        cnt2 = (cnt1 != COUNT_MAX) ? (cnt1 + 16'd1) : cnt1;
        wid2 = (lchars > wid1) ? lchars : wid1;
    end

    always_comb
    begin
        r1.line_start    = 16'(start_reg);
        r1.line_length   = 9'(r1_len);
        r1.is_final      = 1'b0;
        r1.lines_so_far  = cnt1;
        r1.widest_so_far = 9'(wid1);
        r2.line_start    = 16'(lstart);
        r2.line_length   = 9'(lchars);
        r2.is_final      = 1'b1;
        r2.lines_so_far  = cnt2;
        r2.widest_so_far = 9'(wid2);
        push.first  = accept && (r1_valid || r2_valid);
        push.second = accept && r1_valid && r2_valid;
        res0 = r1_valid ? r1 : r2;
        res1 = r2;
    end

    always_comb
    begin
        if (ends)
        begin
            start_next    = '0;
            chars_next    = '0;
            space_next    = '0;
            count_next    = '0;
            widest_next   = '0;
        end
        else
        begin
            start_next    = lstart;
            chars_next    = lchars;
            space_next    = lspace;
            count_next    = cnt1;
            widest_next   = wid1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_width_reg <= WIDTH_RESET;
            text_pos_reg   <= '0;
            start_reg      <= '0;
            chars_reg      <= '0;
            space_reg      <= '0;
            count_reg      <= '0;
            widest_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                wrap_width_reg <= cfg_wdata;
            end
            if (accept)
            begin
                text_pos_reg <= ends ? '0 : text_pos_next;
                start_reg    <= start_next;
                chars_reg    <= chars_next;
                space_reg    <= space_next;
                count_reg    <= count_next;
                widest_reg   <= widest_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_second_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> (end_only || is_last))
        else $error("second line without end of text");

    a_zero_width_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && w_zero) |-> !push.first)
        else $error("line emitted at zero width");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ends) |=> (chars_reg == '0) && (count_reg == '0) && (text_pos_reg == '0))
        else $error("text state not cleared after end");
`endif

endmodule

/* rtl/mww_fifo.sv */
module mww_fifo
    import mww_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  res_t  din0,
    input  res_t  din1,
    output logic  room,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  dout
);

    res_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_push;
    logic             pop;

    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign dout      = entry_reg[head_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = CNT_W'(push.first) + CNT_W'(push.second);

    always_comb
    begin
        head_next  = pop ? (head_reg + PTR_W'(1)) : head_reg;
        tail_next  = tail_reg + PTR_W'(n_push);
        count_next = count_reg + n_push - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            entry_reg[tail_reg] <= din0;
        end
        if (push.second)
        begin
            entry_reg[tail_reg + PTR_W'(1)] <= din1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> room)
        else $error("two words pushed without room");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (!pop && !push.first) |=> $stable(count_reg))
        else $error("count moved while idle");
`endif

endmodule

/* rtl/monospace_word_wrap_top.sv */
// channel | signals                               | dir
// --------+---------------------------------------+-----
// in      | in_valid/in_ready, char_code,         | in
//         | is_last, end_only                     |
// out     | out_valid/out_ready, line_start,      | out
//         | line_length, is_final, lines_so_far,  |
//         | widest_so_far                         |
// cfg     | cfg_we, cfg_wdata (wrap width)        | in
//
// One character word per cycle while in_ready is high; its lines land in the output queue next cycle.
// An end of text can add a second word, which the 4-entry queue absorbs.
// in_ready drops only when fewer than two queue slots are free.
// rst_n clears all text state; wrap width resets to 80.
module monospace_word_wrap_top
    import mww_pkg::*;
#(
    parameter int MAX_WIDTH     = 255,
    parameter int POSITION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        is_last,
    input  logic        end_only,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] line_start,
    output logic [8:0]  line_length,
    output logic        is_final,
    output logic [15:0] lines_so_far,
    output logic [8:0]  widest_so_far
);

    logic  accept;
    push_t push;
    res_t  res0, res1;
    res_t  dout;

    assign accept = in_valid && in_ready;

    mww_core #(
        .MAX_WIDTH     (MAX_WIDTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .char_code (char_code),
        .is_last   (is_last),
        .end_only  (end_only),
        .push      (push),
        .res0      (res0),
        .res1      (res1)
    );

    mww_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din0      (res0),
        .din1      (res1),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dout      (dout)
    );

    assign line_start    = dout.line_start;
    assign line_length   = dout.line_length;
    assign is_final      = dout.is_final;
    assign lines_so_far  = dout.lines_so_far;
    assign widest_so_far = dout.widest_so_far;

endmodule

/* dv/mww_checker.sv */
`timescale 1ns / 1ps

module mww_checker
    import mww_pkg::*;
#(
    parameter int MAX_WIDTH = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        is_last,
    input  logic        end_only,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] line_start,
    input  logic [8:0]  line_length,
    input  logic        is_final,
    input  logic [15:0] lines_so_far,
    input  logic [8:0]  widest_so_far,
    output int          errors,
    output int          pending
);

    logic [7:0]  col_width;
    logic [15:0] next_pos;
    logic [15:0] open_start;
    logic [8:0]  open_fill;
    logic [7:0]  last_gap;
    logic [15:0] line_total;
    logic [8:0]  widest;
    res_t        lines_due[$];
    res_t        want;

    function automatic logic ws_char(input logic [7:0] c);
        return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
    endfunction

    task automatic clear_text();
        next_pos   = '0;
        open_start = '0;
        open_fill  = '0;
        last_gap   = '0;
        line_total = '0;
        widest     = '0;
    endtask

    task automatic close_line(input logic [8:0] len, input logic fin);
        res_t r;
        if (line_total != COUNT_MAX)
            line_total = line_total + 16'd1;
        if (len > widest)
            widest = len;
        r.line_start    = open_start;
        r.line_length   = len;
        r.is_final      = fin;
        r.lines_so_far  = line_total;
        r.widest_so_far = widest;
        lines_due.push_back(r);
    endtask

    task automatic wrap_char(input logic [7:0] c, input logic last, input logic eot);
        logic [8:0]  w;
        logic [15:0] nxt;
        logic        ends;
        w = 9'(col_width);
        if (w > MAX_WIDTH)
            w = 9'(MAX_WIDTH);
        if (!eot)
        begin
            nxt = next_pos + 16'd1;
            if (w == 0)
            begin
                open_start = nxt;
                open_fill  = '0;
                last_gap   = '0;
            end
            else if (open_fill < w)
            begin
                if (c == NEWLINE_CODE)
                begin
                    close_line(open_fill, 1'b0);
                    open_start = nxt;
                    open_fill  = '0;
                    last_gap   = '0;
                end
                else
                begin
                    if (ws_char(c) && open_fill >= 1)
                        last_gap = open_fill[7:0];
                    open_fill = open_fill + 9'd1;
                end
            end
            else if (c == NEWLINE_CODE)
            begin
                close_line(open_fill, 1'b0);
                open_start = nxt;
                open_fill  = '0;
                last_gap   = '0;
            end
            else if (ws_char(c))
            begin
                // full line keeps the blank as one extra column
                close_line(open_fill + 9'd1, 1'b0);
                open_start = nxt;
                open_fill  = '0;
                last_gap   = '0;
            end
            else if (last_gap > 0 && 9'(last_gap) < open_fill)
            begin
                close_line(9'(last_gap) + 9'd1, 1'b0);
                open_start = open_start + 16'(last_gap) + 16'd1;
                open_fill  = open_fill - 9'(last_gap);
                last_gap   = '0;
            end
            else
            begin
                // forced break, new char opens the next line
                close_line(open_fill, 1'b0);
                open_start = next_pos;
                open_fill  = 9'd1;
                last_gap   = '0;
            end
            next_pos = nxt;
            ends     = last;
        end
        else
        begin
            ends = 1'b1;
        end
        if (ends)
        begin
            if (w != 0)
                close_line(open_fill, 1'b1);
            clear_text();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_width = WIDTH_RESET;
            clear_text();
            lines_due.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                col_width = cfg_wdata;
            if (in_valid && in_ready)
                wrap_char(char_code, is_last, end_only);
            if (out_valid && out_ready)
            begin
                if (lines_due.size() == 0)
                begin
                    $error("line word arrived with nothing expected");
                    errors++;
                end
                else
                begin
                    want = lines_due.pop_front();
                    if (line_start !== want.line_start)
                    begin
                        $error("line_start: expected %0d, got %0d", want.line_start, line_start);
                        errors++;
                    end
                    if (line_length !== want.line_length)
                    begin
                        $error("line_length: expected %0d, got %0d",
                               want.line_length, line_length);
                        errors++;
                    end
                    if (is_final !== want.is_final)
                    begin
                        $error("is_final: expected %0d, got %0d", want.is_final, is_final);
                        errors++;
                    end
                    if (lines_so_far !== want.lines_so_far)
                    begin
                        $error("lines_so_far: expected %0d, got %0d",
                               want.lines_so_far, lines_so_far);
                        errors++;
                    end
                    if (widest_so_far !== want.widest_so_far)
                    begin
                        $error("widest_so_far: expected %0d, got %0d",
                               want.widest_so_far, widest_so_far);
                        errors++;
                    end
                end
            end
            pending = lines_due.size();
        end
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import mww_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_code;
    logic        is_last;
    logic        end_only;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] line_start;
    logic [8:0]  line_length;
    logic        is_final;
    logic [15:0] lines_so_far;
    logic [8:0]  widest_so_far;

    int errors;
    int pending;
    int cycles;
    int send_idle;
    int recv_idle;
    int hold_req;
    int text_left;
    int width_now;

    monospace_word_wrap_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .is_last       (is_last),
        .end_only      (end_only),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .line_start    (line_start),
        .line_length   (line_length),
        .is_final      (is_final),
        .lines_so_far  (lines_so_far),
        .widest_so_far (widest_so_far)
    );

    mww_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .is_last       (is_last),
        .end_only      (end_only),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .line_start    (line_start),
        .line_length   (line_length),
        .is_final      (is_final),
        .lines_so_far  (lines_so_far),
        .widest_so_far (widest_so_far),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // line sink: random stalls plus one long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return 8'h20;
        if (r < 15)
            return NEWLINE_CODE;
        if (r < 19)
        begin
            case ($urandom_range(5))
                0: return 8'h09;
                1: return 8'h0B;
                2: return 8'h0C;
                3: return 8'h0D;
                4: return 8'h85;
                default: return 8'hA0;
            endcase
        end
        if (r < 27)
            return 8'($urandom_range(255));
        return 8'($urandom_range(122, 97));
    endfunction

    function automatic logic [7:0] seg_width(input int s);
        case (s)
            0: return 8'd3;
            1: return 8'd255;
            2: return 8'd0;
            3: return 8'd12;
            4: return 8'd1;
            5: return 8'd40;
            6: return 8'd7;
            7: return 8'd80;
            8: return 8'd2;
            9: return 8'd5;
            10: return 8'd200;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // called on a falling edge; returns on the falling edge after acceptance
    task automatic send_word(input logic [7:0] c, input logic last, input logic eot);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        is_last   <= last;
        end_only  <= eot;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_width(input logic [7:0] w);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we    <= 1'b0;
        width_now = w;
    endtask

    task automatic send_random(input int count);
        logic [7:0] c;
        for (int i = 0; i < count; i++)
        begin
            if (text_left == 0)
                text_left = $urandom_range(1, (width_now > 100) ? 400 : 3 * width_now + 12);
            c = pick_char();
            text_left--;
            if (text_left == 0)
            begin
                if ($urandom_range(3) == 0)
                    send_word(c, 1'($urandom_range(1)), 1'b1);
                else
                    send_word(c, 1'b1, 1'b0);
            end
            else if ($urandom_range(199) == 0)
            begin
                send_word(c, 1'($urandom_range(1)), 1'b1);
                text_left = 0;
            end
            else
            begin
                send_word(c, 1'b0, 1'b0);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        char_code = '0;
        is_last   = 1'b0;
        end_only  = 1'b0;
        cycles    = 0;
        send_idle = 0;
        recv_idle = 0;
        hold_req  = 0;
        text_left = 0;
        width_now = 80;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: word break, kept blank, forced break, newlines, end cases
        set_width(8'd4);
        send_word(8'h61, 1'b0, 1'b0);
        send_word(8'h62, 1'b0, 1'b0);
        send_word(8'h20, 1'b0, 1'b0);
        send_word(8'h63, 1'b0, 1'b0);
        send_word(8'h64, 1'b0, 1'b0);
        send_word(8'h65, 1'b0, 1'b0);
        send_word(8'h66, 1'b0, 1'b0);
        send_word(8'h09, 1'b0, 1'b0);
        send_word(8'h67, 1'b0, 1'b0);
        send_word(8'h68, 1'b0, 1'b0);
        send_word(8'h69, 1'b0, 1'b0);
        send_word(8'h6A, 1'b0, 1'b0);
        send_word(8'h6B, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h85, 1'b0, 1'b0);
        send_word(8'hA0, 1'b0, 1'b0);
        send_word(NEWLINE_CODE, 1'b0, 1'b0);
        send_word(NEWLINE_CODE, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(NEWLINE_CODE, 1'b1, 1'b1);
        set_width(8'd0);
        send_word(8'h0D, 1'b0, 1'b0);
        send_word(8'h78, 1'b1, 1'b0);
        // width lowered under an open line
        set_width(8'd8);
        send_word(8'h70, 1'b0, 1'b0);
        send_word(8'h20, 1'b0, 1'b0);
        send_word(8'h71, 1'b0, 1'b0);
        set_width(8'd2);
        send_word(8'h72, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);

        for (int m = 0; m < 3; m++)
        begin
            send_idle = (m == 0) ? 33 : (m == 1) ? 84 : 0;
            recv_idle = (m == 0) ? 84 : (m == 1) ? 33 : 0;
            for (int k = 0; k < 4; k++)
            begin
                set_width(seg_width(4 * m + k));
                if (m == 2 && k == 1)
                    hold_req++;
                if (m == 1 && k == 2)
                begin
                    send_random(60);
                    settle();
                    send_random(90);
                end
                else
                begin
                    send_random(150);
                end
            end
        end

        // short text at width 1: nearly every character closes a line
        set_width(8'd1);
        for (int i = 0; i < 24; i++)
        begin
            if ($urandom_range(19) == 0)
                send_word(pick_char(), 1'b0, 1'b0);
            else
                send_word(8'($urandom_range(122, 97)), 1'b0, 1'b0);
        end
        send_word(8'($urandom_range(255)), 1'b0, 1'b1);

        settle();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/mww_pkg.sv
rtl/mww_core.sv
rtl/mww_fifo.sv
rtl/monospace_word_wrap_top.sv
dv/mww_checker.sv
dv/tb.sv
